// ----- sv/bbtc_pkg.sv -----
// shared constants for the bounding-box triangle coverage block
`default_nettype none
package bbtc_pkg;

  localparam int COORD_BITS = 12;
  localparam int COLOR_BITS = 32;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

endpackage
`default_nettype wire

// ----- sv/bbox_triangle_coverage.sv -----
// top level: triangle load, bounding-box scan and per-pixel coverage output
// a tick item passes through the input register, then into the result register once it is free
// throughput: one item per cycle unless output stalls, set by the combinational edge test and scan step
// a load item gives no result; a tick while idle gives nothing
// rst (synchronous, active high) empties both registers and leaves the block idle
`default_nettype none
module bbox_triangle_coverage #(
  parameter int COORD_BITS = bbtc_pkg::COORD_BITS
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y, fill_color
  input  wire logic [((6*COORD_BITS+bbtc_pkg::COLOR_BITS+7)/8)*8-1:0] s_axis_tdata,
  // kind
  input  wire logic [0:0] s_axis_tuser,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // pix_x, pix_y, pix_color
  output logic [((2*COORD_BITS+bbtc_pkg::COLOR_BITS+7)/8)*8-1:0] m_axis_tdata,
  // covered
  output logic [0:0] m_axis_tuser,
  // last
  output logic      m_axis_tlast
);

  localparam int CB    = COORD_BITS;
  localparam int CW    = bbtc_pkg::COLOR_BITS;
  localparam int OUT_W = ((2*COORD_BITS+bbtc_pkg::COLOR_BITS+7)/8)*8;

  function automatic logic signed [CB-1:0] min3(
    input logic signed [CB-1:0] a,
    input logic signed [CB-1:0] b,
    input logic signed [CB-1:0] c
  );
    logic signed [CB-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [CB-1:0] max3(
    input logic signed [CB-1:0] a,
    input logic signed [CB-1:0] b,
    input logic signed [CB-1:0] c
  );
    logic signed [CB-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // input register
  logic                 in_valid;
  logic                 in_kind;
  logic signed [CB-1:0] in_ax, in_ay, in_bx, in_by, in_cx, in_cy;
  logic [CW-1:0]        in_color;

  // triangle state
  logic signed [CB-1:0] vert_ax, vert_ay, vert_bx, vert_by, vert_cx, vert_cy;
  logic signed [CB-1:0] box_x_min, box_x_max, box_y_min, box_y_max;
  logic signed [CB-1:0] scan_x, scan_y;
  logic [CW-1:0]        held_color;
  logic                 active;

  // result register
  logic                 out_valid;
  logic signed [CB-1:0] out_x, out_y;
  logic [CW-1:0]        out_color;
  logic                 out_cov;
  logic                 out_last;

  logic proc_fire;
  logic load_fire;
  logic tick_fire;
  logic fin;
  logic cov;

  assign proc_fire     = in_valid && (!out_valid || m_axis_tready);
  assign load_fire     = proc_fire && (in_kind == bbtc_pkg::KIND_LOAD);
  assign tick_fire     = proc_fire && (in_kind == bbtc_pkg::KIND_TICK) && active;
  assign s_axis_tready = !in_valid || proc_fire;
  assign fin           = (scan_x == box_x_max) && (scan_y == box_y_max);

  bbtc_edge #(
    .COORD_BITS(COORD_BITS)
  ) u_edge (
    .px     (scan_x),
    .py     (scan_y),
    .ax     (vert_ax),
    .ay     (vert_ay),
    .bx     (vert_bx),
    .by     (vert_by),
    .cx     (vert_cx),
    .cy     (vert_cy),
    .covered(cov)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_kind  <= s_axis_tuser[0];
      in_ax    <= s_axis_tdata[0*CB +: CB];
      in_ay    <= s_axis_tdata[1*CB +: CB];
      in_bx    <= s_axis_tdata[2*CB +: CB];
      in_by    <= s_axis_tdata[3*CB +: CB];
      in_cx    <= s_axis_tdata[4*CB +: CB];
      in_cy    <= s_axis_tdata[5*CB +: CB];
      in_color <= s_axis_tdata[6*CB +: CW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (load_fire) begin
      active <= 1'b1;
    end else if (tick_fire && fin) begin
      active <= 1'b0;
    end
    if (load_fire) begin
      vert_ax    <= in_ax;
      vert_ay    <= in_ay;
      vert_bx    <= in_bx;
      vert_by    <= in_by;
      vert_cx    <= in_cx;
      vert_cy    <= in_cy;
      held_color <= in_color;
      box_x_min  <= min3(in_ax, in_bx, in_cx);
      box_x_max  <= max3(in_ax, in_bx, in_cx);
      box_y_min  <= min3(in_ay, in_by, in_cy);
      box_y_max  <= max3(in_ay, in_by, in_cy);
      scan_x     <= min3(in_ax, in_bx, in_cx);
      scan_y     <= min3(in_ay, in_by, in_cy);
    end else if (tick_fire && !fin) begin
      if (scan_y < box_y_max) begin
        scan_y <= scan_y + CB'(1);
      end else begin
        scan_y <= box_y_min;
        scan_x <= scan_x + CB'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick_fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (tick_fire) begin
      out_x     <= scan_x;
      out_y     <= scan_y;
      out_color <= held_color;
      out_cov   <= cov;
      out_last  <= fin;
    end
  end

  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = OUT_W'({out_color, out_y, out_x});
  assign m_axis_tuser[0] = out_cov;
  assign m_axis_tlast    = out_last;

  // scan position stays inside the box
  a_scan_in_box: assert property (@(posedge clk) disable iff (rst)
    active |-> (scan_y >= box_y_min) && (scan_y <= box_y_max)
               && (scan_x >= box_x_min) && (scan_x <= box_x_max))
    else $error("scan position outside bounding box");

  // the final pixel ends the scan
  a_last_idles: assert property (@(posedge clk) disable iff (rst)
    (tick_fire && fin) |=> !active && out_valid && out_last)
    else $error("scan did not end on final pixel");

  // a load restarts the scan at the box corner
  a_load_start: assert property (@(posedge clk) disable iff (rst)
    load_fire |=> active && (scan_x == box_x_min) && (scan_y == box_y_min))
    else $error("load did not park scan at box corner");

  // no result is produced while idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (!tick_fire && !out_valid) |=> !out_valid)
    else $error("result appeared without a tick");

endmodule
`default_nettype wire

// ----- sv/bbtc_edge.sv -----
// edge function coverage test of one pixel against a triangle
`default_nettype none
module bbtc_edge #(
  parameter int COORD_BITS = bbtc_pkg::COORD_BITS
) (
  input  wire logic signed [COORD_BITS-1:0] px,
  input  wire logic signed [COORD_BITS-1:0] py,
  input  wire logic signed [COORD_BITS-1:0] ax,
  input  wire logic signed [COORD_BITS-1:0] ay,
  input  wire logic signed [COORD_BITS-1:0] bx,
  input  wire logic signed [COORD_BITS-1:0] by,
  input  wire logic signed [COORD_BITS-1:0] cx,
  input  wire logic signed [COORD_BITS-1:0] cy,
  output logic                              covered
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * COORD_BITS + 2;
  localparam int EW = 2 * COORD_BITS + 3;

  function automatic logic edge_neg(
    input logic signed [COORD_BITS-1:0] ppx,
    input logic signed [COORD_BITS-1:0] ppy,
    input logic signed [COORD_BITS-1:0] ux,
    input logic signed [COORD_BITS-1:0] uy,
    input logic signed [COORD_BITS-1:0] vx,
    input logic signed [COORD_BITS-1:0] vy
  );
    logic signed [DW-1:0] dux;
    logic signed [DW-1:0] duy;
    logic signed [DW-1:0] dvx;
    logic signed [DW-1:0] dvy;
    logic signed [PW-1:0] m1;
    logic signed [PW-1:0] m2;
    logic signed [EW-1:0] d;
    dux = DW'(ux) - DW'(ppx);
    duy = DW'(uy) - DW'(ppy);
    dvx = DW'(vx) - DW'(ppx);
    dvy = DW'(vy) - DW'(ppy);
    m1  = PW'(dux) * PW'(dvy);
    m2  = PW'(duy) * PW'(dvx);
    d   = EW'(m1) - EW'(m2);
    return d[EW-1];
  endfunction

  logic e1;
  logic e2;
  logic e3;

  always_comb begin
    e1 = edge_neg(px, py, ax, ay, bx, by);
    e2 = edge_neg(px, py, bx, by, cx, cy);
    e3 = edge_neg(px, py, cx, cy, ax, ay);
    covered = (e1 == e2) && (e2 == e3);
  end

endmodule
`default_nettype wire
